### sv/htn_pkg.sv
// Shared constants, types and helper functions of the height to normal map block.
package htn_pkg;

   // Map geometry and sample format.
   localparam int MAP_SIDE    = 1024;
   localparam int HEIGHT_BITS = 16;

   localparam int CELLS = MAP_SIDE * MAP_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(MAP_SIDE);
   localparam int HB    = HEIGHT_BITS;

   // Squared lengths stay below 3 * 2^(2*HB); scaled products carry 16 more bits.
   localparam int QW = 2 * HB + 2;
   localparam int RW = QW + 16;

   // 255 squared scales the right side of every byte threshold test.
   localparam logic [15:0] BYTE_SCALE_SQ = 16'd65025;
   localparam logic [QW-1:0] UNIT_SQ = QW'(1) << (2 * HB);
   localparam logic [RW-1:0] UNIT_RHS = RW'(BYTE_SCALE_SQ) << (2 * HB);

   // Command codes.
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_COMPUTE = 1'b1;

   // Samples of the five taps read for one pixel.
   typedef struct packed {
      logic [HB-1:0] self;
      logic [HB-1:0] east;
      logic [HB-1:0] west;
      logic [HB-1:0] south;
      logic [HB-1:0] north;
   } taps_type;

   // One normal component under search: sign of its numerator, scaled square, byte so far.
   typedef struct packed {
      logic          neg;
      logic [RW-1:0] rhs;
      logic [7:0]    res;
   } lane_type;

   // Data carried through the byte search pipeline.
   typedef struct packed {
      logic [QW-1:0]     q;
      lane_type [2:0]    lane;
      logic [7:0]        probe;
      logic [7:0]        hbyte;
   } search_type;

   // Reduces a coordinate into the map by subtracting scaled copies of the side.
   function automatic logic [CW-1:0] wrap_coord(input logic [9:0] v);
      logic [12:0] r;
      r = {3'b000, v};
      for (int j = 9; j >= 0; j--) begin
         if ((MAP_SIDE << j) <= 1023) begin
            if (r >= 13'(MAP_SIDE << j)) begin
               r = r - 13'(MAP_SIDE << j);
            end
         end
      end
      return CW'(r);
   endfunction

   // Linear store address of a reduced coordinate pair.
   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
      return AW'(y) * AW'(MAP_SIDE) + AW'(x);
   endfunction

endpackage

### sv/htn_height_ram.sv
// Single write port, single registered read port height sample memory.
module htn_height_ram import htn_pkg::*; (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [HB-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [HB-1:0] rd_data_ff
);

   logic [HB-1:0] mem [CELLS];

   // Write and read in the same clocked block; reads hold when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### sv/htn_fetch.sv
// Input register, address generation and the five tap memories.
module htn_fetch import htn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [9:0]  req_column,
   input  logic [9:0]  req_row,
   input  logic signed [15:0] req_height_value,
   output logic        out_valid,
   input  logic        out_ready,
   output taps_type    out_data
);

   logic        v0_ff, v0_in, v1_ff, v1_in;
   logic        cmd0_ff;
   logic [9:0]  col0_ff, row0_ff;
   logic [15:0] hv0_ff;
   logic        en0, en1;
   logic        wr_en, rd_en;
   logic [CW-1:0] xr, yr, xe, xw, ys, yn;
   logic [15:0]   offset_val;
   logic [HB-1:0] sample;
   logic [AW-1:0] a_self, a_east, a_west, a_south, a_north;
   logic [HB-1:0] d_self, d_east, d_west, d_south, d_north;

   // Stage enables: a stage loads when it is empty or its successor moves.
   assign en1       = !v1_ff || out_ready;
   assign en0       = !v0_ff || en1;
   assign req_ready = en0;
   assign v0_in     = req_valid;
   assign v1_in     = v0_ff && (cmd0_ff == CMD_COMPUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         if (en0) begin
            v0_ff <= v0_in;
         end
         if (en1) begin
            v1_ff <= v1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         cmd0_ff <= req_command;
         col0_ff <= req_column;
         row0_ff <= req_row;
         hv0_ff  <= req_height_value;
      end
   end

   // Wrapped coordinates of the pixel and its four neighbors.
   always_comb begin
      xr = wrap_coord(col0_ff);
      yr = wrap_coord(row0_ff);
      xe = (xr == CW'(MAP_SIDE - 1)) ? '0 : xr + CW'(1);
      xw = (xr == '0) ? CW'(MAP_SIDE - 1) : xr - CW'(1);
      ys = (yr == CW'(MAP_SIDE - 1)) ? '0 : yr + CW'(1);
      yn = (yr == '0) ? CW'(MAP_SIDE - 1) : yr - CW'(1);
      a_self  = cell_addr(xr, yr);
      a_east  = cell_addr(xe, yr);
      a_west  = cell_addr(xw, yr);
      a_south = cell_addr(xr, ys);
      a_north = cell_addr(xr, yn);
   end

   // Offset binary sample aligned to the stored width.
   assign offset_val = {~hv0_ff[15], hv0_ff[14:0]};
   assign sample     = HB'({offset_val, 8'h00} >> (24 - HB));

   assign wr_en = en1 && v0_ff && (cmd0_ff == CMD_WRITE);
   assign rd_en = en1 && v0_ff && (cmd0_ff == CMD_COMPUTE);

   // Every copy takes every write, so each tap has its own read port.
   htn_height_ram u_ram_self (
      .clock(clock), .wr_en(wr_en), .wr_addr(a_self), .wr_data(sample),
      .rd_en(rd_en), .rd_addr(a_self), .rd_data_ff(d_self)
   );
   htn_height_ram u_ram_east (
      .clock(clock), .wr_en(wr_en), .wr_addr(a_self), .wr_data(sample),
      .rd_en(rd_en), .rd_addr(a_east), .rd_data_ff(d_east)
   );
   htn_height_ram u_ram_west (
      .clock(clock), .wr_en(wr_en), .wr_addr(a_self), .wr_data(sample),
      .rd_en(rd_en), .rd_addr(a_west), .rd_data_ff(d_west)
   );
   htn_height_ram u_ram_south (
      .clock(clock), .wr_en(wr_en), .wr_addr(a_self), .wr_data(sample),
      .rd_en(rd_en), .rd_addr(a_south), .rd_data_ff(d_south)
   );
   htn_height_ram u_ram_north (
      .clock(clock), .wr_en(wr_en), .wr_addr(a_self), .wr_data(sample),
      .rd_en(rd_en), .rd_addr(a_north), .rd_data_ff(d_north)
   );

   assign out_valid      = v1_ff;
   assign out_data.self  = d_self;
   assign out_data.east  = d_east;
   assign out_data.west  = d_west;
   assign out_data.south = d_south;
   assign out_data.north = d_north;

endmodule

### sv/htn_slope.sv
// Central differences, their squares and the squared normal length.
module htn_slope import htn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  taps_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output search_type out_data
);

   typedef struct packed {
      logic [HB:0] mx;
      logic [HB:0] my;
      logic        nx;
      logic        ny;
      logic [7:0]  hbyte;
   } diff_type;

   typedef struct packed {
      logic [QW-1:0] sqx;
      logic [QW-1:0] sqy;
      logic          nx;
      logic          ny;
      logic [7:0]    hbyte;
   } square_type;

   logic       v2_ff, v3_ff, v4_ff;
   logic       en2, en3, en4;
   diff_type   s2_ff, s2_in;
   square_type s3_ff, s3_in;
   search_type s4_ff, s4_in;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) v2_ff <= in_valid;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Differences as magnitude and the sign of the negated difference.
   always_comb begin
      logic signed [HB:0] dx, dy;
      logic [HB+7:0]      scaled;
      dx = $signed({1'b0, in_data.east}) - $signed({1'b0, in_data.west});
      dy = $signed({1'b0, in_data.south}) - $signed({1'b0, in_data.north});
      s2_in.mx = dx[HB] ? (HB+1)'(-dx) : (HB+1)'(dx);
      s2_in.my = dy[HB] ? (HB+1)'(-dy) : (HB+1)'(dy);
      s2_in.nx = !dx[HB] && (dx != '0);
      s2_in.ny = !dy[HB] && (dy != '0);
      scaled   = {in_data.self, 8'h00} - (HB+8)'(in_data.self);
      s2_in.hbyte = 8'(scaled >> HB);
   end

   // Squares of the differences.
   always_comb begin
      s3_in.sqx   = QW'(s2_ff.mx) * QW'(s2_ff.mx);
      s3_in.sqy   = QW'(s2_ff.my) * QW'(s2_ff.my);
      s3_in.nx    = s2_ff.nx;
      s3_in.ny    = s2_ff.ny;
      s3_in.hbyte = s2_ff.hbyte;
   end

   // Squared length and the scaled numerator squares that start the search.
   always_comb begin
      s4_in.q            = s3_ff.sqx + s3_ff.sqy + UNIT_SQ;
      s4_in.lane[0].neg  = s3_ff.nx;
      s4_in.lane[0].rhs  = RW'(BYTE_SCALE_SQ) * RW'(s3_ff.sqx);
      s4_in.lane[0].res  = 8'h00;
      s4_in.lane[1].neg  = s3_ff.ny;
      s4_in.lane[1].rhs  = RW'(BYTE_SCALE_SQ) * RW'(s3_ff.sqy);
      s4_in.lane[1].res  = 8'h00;
      s4_in.lane[2].neg  = 1'b0;
      s4_in.lane[2].rhs  = UNIT_RHS;
      s4_in.lane[2].res  = 8'h00;
      s4_in.probe        = 8'h80;
      s4_in.hbyte        = s3_ff.hbyte;
   end

   always_ff @(posedge clock) begin
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

### sv/htn_search_step.sv
// One bit of the exact byte search for all three normal components.
module htn_search_step import htn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  search_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output search_type out_data
);

   typedef struct packed {
      search_type       base;
      logic [2:0]       tpos;
      logic [2:0][7:0]  cand;
      logic [2:0][15:0] tsq;
   } probe_type;

   logic       va_ff, vb_ff;
   logic       ena, enb;
   probe_type  a_ff, a_in;
   search_type b_ff, b_in;

   assign enb      = !vb_ff || out_ready;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= in_valid;
         if (enb) vb_ff <= va_ff;
      end
   end

   // Candidate byte c and the square of its threshold t = 2c - 255.
   always_comb begin
      logic [7:0] c, tm;
      a_in.base = in_data;
      for (int i = 0; i < 3; i++) begin
         c  = in_data.lane[i].res | in_data.probe;
         tm = {c[7] ? c[6:0] : ~c[6:0], 1'b1};
         a_in.cand[i] = c;
         a_in.tpos[i] = c[7];
         a_in.tsq[i]  = 16'(tm) * 16'(tm);
      end
   end

   // Keep the candidate when t * |n| stays at or below 255 * numerator.
   always_comb begin
      logic [RW-1:0] lhs;
      logic          pass;
      b_in = a_ff.base;
      for (int i = 0; i < 3; i++) begin
         lhs = RW'(a_ff.tsq[i]) * RW'(a_ff.base.q);
         if (!a_ff.tpos[i] && !a_ff.base.lane[i].neg) begin
            pass = 1'b1;
         end else if (a_ff.tpos[i] && a_ff.base.lane[i].neg) begin
            pass = 1'b0;
         end else if (a_ff.tpos[i]) begin
            pass = (lhs <= a_ff.base.lane[i].rhs);
         end else begin
            pass = (a_ff.base.lane[i].rhs <= lhs);
         end
         if (pass) begin
            b_in.lane[i].res = a_ff.cand[i];
         end
      end
      b_in.probe = a_ff.base.probe >> 1;
   end

   always_ff @(posedge clock) begin
      if (ena) a_ff <= a_in;
      if (enb) b_ff <= b_in;
   end

   assign out_valid = vb_ff;
   assign out_data  = b_ff;

endmodule

### sv/height_to_normal_map_top.sv
// Top level of the height map to normal map block.
// Takes one request per clock cycle while the result side does not stall, writes or computes
// alike, and a compute request returns its four bytes after the input register, the tap
// memory read, the registers for differences, squares and the squared length, and the
// probe and decision registers of each of the eight bits of the exact byte search.
// The rate is set by the five copies of the height store, one read port per tap, all
// written together. Write requests return nothing. Each normal byte is the exact floor of
// (c + 1) * 127.5, found by a bitwise search on integer compares. A stall at the result
// side holds the pipeline stage by stage, and empty stages still take new requests.
module height_to_normal_map_top import htn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [9:0]        req_column,
   input  logic [9:0]        req_row,
   input  logic signed [15:0] req_height_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_normal_x_byte,
   output logic [7:0]        rsp_normal_y_byte,
   output logic [7:0]        rsp_normal_z_byte,
   output logic [7:0]        rsp_height_byte
);

   logic       taps_valid, taps_ready;
   taps_type   taps;
   logic       stage_valid [9];
   logic       stage_ready [9];
   search_type stage_data  [9];

   // Memory fetch.
   htn_fetch u_fetch (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_column(req_column),
      .req_row(req_row), .req_height_value(req_height_value),
      .out_valid(taps_valid), .out_ready(taps_ready), .out_data(taps)
   );

   // Slopes and squared length.
   htn_slope u_slope (
      .clock(clock), .reset(reset),
      .in_valid(taps_valid), .in_ready(taps_ready), .in_data(taps),
      .out_valid(stage_valid[0]), .out_ready(stage_ready[0]), .out_data(stage_data[0])
   );

   // Eight search steps, most significant bit first.
   for (genvar g = 0; g < 8; g++) begin : g_search
      htn_search_step u_step (
         .clock(clock), .reset(reset),
         .in_valid(stage_valid[g]), .in_ready(stage_ready[g]), .in_data(stage_data[g]),
         .out_valid(stage_valid[g+1]), .out_ready(stage_ready[g+1]),
         .out_data(stage_data[g+1])
      );
   end

   // The last search register is the output register.
   assign stage_ready[8]    = rsp_ready;
   assign rsp_valid         = stage_valid[8];
   assign rsp_normal_x_byte = stage_data[8].lane[0].res;
   assign rsp_normal_y_byte = stage_data[8].lane[1].res;
   assign rsp_normal_z_byte = stage_data[8].lane[2].res;
   assign rsp_height_byte   = stage_data[8].hbyte;

   // The z component is always positive, so its byte never falls below the midpoint.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_z_byte >= 8'd127))
      else $error("normal z byte below midpoint");

   // A sample below one maps to at most 254.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_height_byte != 8'hFF))
      else $error("height byte out of range");

   // With the output free, every stage can move, so a request is always taken.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled with free output");

endmodule

### tb/tb.sv
// Self-checking testbench for the height map to normal map block.
module tb;
   import htn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 60;

   // Result bytes of one compute request.
   typedef struct {
      logic [7:0] nx;
      logic [7:0] ny;
      logic [7:0] nz;
      logic [7:0] hb;
   } normal_bytes_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_command;
   logic [9:0] req_column;
   logic [9:0] req_row;
   logic signed [15:0] req_height_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_normal_x_byte;
   logic [7:0] rsp_normal_y_byte;
   logic [7:0] rsp_normal_z_byte;
   logic [7:0] rsp_height_byte;

   // Mirror of the height store in offset binary, plus the written cells.
   logic [15:0] height_mirror [int];
   int written_cells [$];
   normal_bytes_type pending_normals [$];
   int fail_count = 0;
   int cycle_count = 0;
   bit busy_sender = 0;

   height_to_normal_map_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int cell_of(int x, int y);
      return ((y % MAP_SIDE) * MAP_SIDE) + (x % MAP_SIDE);
   endfunction

   // Is t * sqrt(q) <= 255 * m, for odd t in -255..255?
   function automatic bit scaled_le(int t, longint m, longint q);
      longint lhs;
      longint rhs;
      if (t <= 0 && m >= 0) return 1'b1;
      if (t > 0 && m < 0) return 1'b0;
      lhs = longint'(t) * longint'(t) * q;
      rhs = 64'd65025 * m * m;
      if (t > 0) return lhs <= rhs;
      return rhs <= lhs;
   endfunction

   // Exact floor of 127.5 * (1 + m / sqrt(q)) by binary search.
   function automatic logic [7:0] floor_byte(longint m, longint q);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (scaled_le(2 * mid - 255, m, q)) lo = mid;
         else hi = mid - 1;
      end
      return lo[7:0];
   endfunction

   function automatic normal_bytes_type predict_normal(int x, int y);
      normal_bytes_type r;
      longint dx;
      longint dy;
      longint q;
      longint self_h;
      dx = longint'(height_mirror[cell_of(x + 1, y)])
         - longint'(height_mirror[cell_of(x + MAP_SIDE - 1, y)]);
      dy = longint'(height_mirror[cell_of(x, y + 1)])
         - longint'(height_mirror[cell_of(x, y + MAP_SIDE - 1)]);
      q = dx * dx + dy * dy + (longint'(1) << 32);
      r.nx = floor_byte(-dx, q);
      r.ny = floor_byte(-dy, q);
      r.nz = floor_byte(longint'(1) << 16, q);
      self_h = longint'(height_mirror[cell_of(x, y)]);
      r.hb = 8'((255 * self_h) >> 16);
      return r;
   endfunction

   // True when the pixel and its four neighbors have all been written.
   function automatic bit taps_known(int x, int y);
      return height_mirror.exists(cell_of(x, y))
         && height_mirror.exists(cell_of(x + 1, y))
         && height_mirror.exists(cell_of(x + MAP_SIDE - 1, y))
         && height_mirror.exists(cell_of(x, y + 1))
         && height_mirror.exists(cell_of(x, y + MAP_SIDE - 1));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [15:0] pick_height();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one request and updates the prediction when it is accepted.
   task automatic send_request(input logic cmd, input int x, input int y,
                               input logic signed [15:0] h);
      int gap;
      gap = busy_sender ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_column = 10'(x);
      req_row = 10'(y);
      req_height_value = h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == CMD_WRITE) begin
         if (!height_mirror.exists(cell_of(x, y))) written_cells.push_back(cell_of(x, y));
         height_mirror[cell_of(x, y)] = 16'(h) ^ 16'h8000;
      end else begin
         pending_normals.push_back(predict_normal(x, y));
      end
   endtask

   // Writes the pixel and its four neighbors, then asks for its normal.
   task automatic send_patch(input int x, input int y, input logic signed [15:0] hs,
                             input logic signed [15:0] he, input logic signed [15:0] hw,
                             input logic signed [15:0] hn, input logic signed [15:0] hso);
      send_request(CMD_WRITE, x, y, hs);
      send_request(CMD_WRITE, (x + 1) % MAP_SIDE, y, he);
      send_request(CMD_WRITE, (x + MAP_SIDE - 1) % MAP_SIDE, y, hw);
      send_request(CMD_WRITE, x, (y + MAP_SIDE - 1) % MAP_SIDE, hn);
      send_request(CMD_WRITE, x, (y + 1) % MAP_SIDE, hso);
      send_request(CMD_COMPUTE, x, y, 16'sh0);
   endtask

   // Extreme heights, a flat patch and corners of the map where taps wrap.
   task automatic test_directed_extremes();
      send_patch(0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_patch(1023, 1023, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_patch(512, 341, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      send_patch(1023, 0, 16'shFFFF, 16'sh8000, 16'sh7FFF, 16'sh1234, 16'shEDCB);
      send_request(CMD_COMPUTE, 0, 0, 16'sh7FFF);
   endtask

   // Mostly full patches with random content, with stray writes and repeat computes.
   task automatic test_random_traffic(input int item_goal);
      int sent;
      int sel;
      int c;
      int tries;
      bit drained;
      sent = 0;
      drained = 1'b0;
      while (sent < item_goal) begin
         if (sent > 0 && sent % 300 == 0) busy_sender = ~busy_sender;
         // Halfway through, stop sending until every result has come back.
         if (!drained && sent >= item_goal / 2) begin
            @(negedge clock);
            req_valid = 1'b0;
            wait (pending_normals.size() == 0);
            drained = 1'b1;
         end
         sel = $urandom_range(0, 9);
         if (sel < 5) begin
            send_patch($urandom_range(0, 1023), $urandom_range(0, 1023), pick_height(),
                       pick_height(), pick_height(), pick_height(), pick_height());
            sent += 6;
         end else if (sel < 7) begin
            send_request(CMD_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         pick_height());
            sent += 1;
         end else begin
            c = cell_of(0, 0);
            tries = 0;
            do begin
               c = written_cells[$urandom_range(0, written_cells.size() - 1)];
               tries++;
            end while (!taps_known(c % MAP_SIDE, c / MAP_SIDE) && tries < 8);
            if (!taps_known(c % MAP_SIDE, c / MAP_SIDE)) c = cell_of(0, 0);
            send_request(CMD_COMPUTE, c % MAP_SIDE, c / MAP_SIDE, 16'(4'($urandom)));
            sent += 1;
         end
      end
      busy_sender = 1'b0;
   endtask

   // Random backpressure on the result side.
   initial begin
      int hold;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready = 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // Compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      normal_bytes_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_normals.size() == 0) begin
            $error("result with no pending compute request");
            fail_count++;
         end else begin
            e = pending_normals.pop_front();
            if (rsp_normal_x_byte !== e.nx) begin
               $error("normal_x_byte expected %0d actual %0d", e.nx, rsp_normal_x_byte);
               fail_count++;
            end
            if (rsp_normal_y_byte !== e.ny) begin
               $error("normal_y_byte expected %0d actual %0d", e.ny, rsp_normal_y_byte);
               fail_count++;
            end
            if (rsp_normal_z_byte !== e.nz) begin
               $error("normal_z_byte expected %0d actual %0d", e.nz, rsp_normal_z_byte);
               fail_count++;
            end
            if (rsp_height_byte !== e.hb) begin
               $error("height_byte expected %0d actual %0d", e.hb, rsp_height_byte);
               fail_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_WRITE;
      req_column = '0;
      req_row = '0;
      req_height_value = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_random_traffic(1150);
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_normals.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_normals.size() != 0) begin
         $error("%0d compute results never arrived", pending_normals.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
